// ===== src/bbtu_pkg.sv =====
// shared types, constants and the bit-reverse function of the barrel bit transform unit
// no dependencies
package bbtu_pkg;

	localparam int unsigned WordW      = 32;
	localparam int unsigned OpW        = 4;
	localparam int unsigned PosW       = 5;
	localparam int unsigned ModeW      = 2;
	localparam int unsigned CountW     = 5;
	localparam int unsigned PresetW    = ModeW + CountW;
	localparam int unsigned NumPresets = 8;
	localparam int unsigned PresetSelW = $clog2(NumPresets);
	localparam int unsigned CfgIdxW    = 4;
	localparam int unsigned FlagW      = 6;
	// data_in, test_mask, bit_pos, padded to whole bytes
	localparam int unsigned InPackW    = 2 * WordW + PosW;
	localparam int unsigned InDataW    = ((InPackW + 7) / 8) * 8;
	localparam int unsigned OutDataW   = WordW;
	localparam int unsigned InUserW    = ((OpW + 7) / 8) * 8;
	localparam int unsigned OutUserW   = ((FlagW + 7) / 8) * 8;

	typedef enum logic [ModeW-1:0] {
		MODE_ROTATE,
		MODE_SHL,
		MODE_SHR,
		MODE_SAR
	} shift_mode_t;

	localparam logic [OpW-1:0] OP_INVERT   = 4'd8;
	localparam logic [OpW-1:0] OP_BIT_TEST = 4'd9;
	localparam logic [OpW-1:0] OP_REVERSE  = 4'd13;
	localparam logic [OpW-1:0] OP_SET      = 4'd14;
	localparam logic [OpW-1:0] OP_CLEAR    = 4'd15;

	typedef logic [PresetW-1:0] preset_t;
	typedef preset_t [NumPresets-1:0] preset_bank_t;

	typedef struct packed {
		logic [OpW-1:0]   op_select;
		logic [WordW-1:0] data_in;
		logic [WordW-1:0] test_mask;
		logic [PosW-1:0]  bit_pos;
	} in_item_t;

	typedef struct packed {
		logic [WordW-1:0] result;
		logic             bit_flag;
		logic             bit_clear_flag;
		logic             masked_zero;
		logic             masked_nonzero;
		logic             zero_flag;
		logic             nonzero_flag;
	} out_item_t;

	function automatic logic [WordW-1:0] reverse_bits(input logic [WordW-1:0] w);
		logic [WordW-1:0] r;
		r = w;
		r = ((r & 32'haaaaaaaa) >> 1) | ((r & 32'h55555555) << 1);
		r = ((r & 32'hcccccccc) >> 2) | ((r & 32'h33333333) << 2);
		r = ((r & 32'hf0f0f0f0) >> 4) | ((r & 32'h0f0f0f0f) << 4);
		r = ((r & 32'hff00ff00) >> 8) | ((r & 32'h00ff00ff) << 8);
		r = {r[15:0], r[31:16]};
		return r;
	endfunction

endpackage

// ===== src/bbtu_funnel.sv =====
// funnel shifter that carries out one shift preset (rotate, shl, shr, sar)
// depends on bbtu_pkg
module bbtu_funnel (
	input  logic [bbtu_pkg::WordW-1:0] word,
	input  bbtu_pkg::preset_t          preset,
	output logic [bbtu_pkg::WordW-1:0] shifted
);

	bbtu_pkg::shift_mode_t                mode;
	logic [bbtu_pkg::CountW-1:0]          count;
	logic [bbtu_pkg::WordW-1:0]           upper;
	logic [bbtu_pkg::WordW-1:0]           lower;
	logic [2*bbtu_pkg::WordW-1:0]         pair;

	assign mode  = bbtu_pkg::shift_mode_t'(preset[bbtu_pkg::PresetW-1:bbtu_pkg::CountW]);
	assign count = preset[bbtu_pkg::CountW-1:0];

	// right shifts by 32-s are the upper half of a left shift by s
	always_comb begin
		case (mode)
			bbtu_pkg::MODE_ROTATE: begin
				upper = word;
				lower = word;
			end
			bbtu_pkg::MODE_SHL: begin
				upper = word;
				lower = '0;
			end
			bbtu_pkg::MODE_SHR: begin
				upper = '0;
				lower = word;
			end
			bbtu_pkg::MODE_SAR: begin
				upper = {bbtu_pkg::WordW{word[bbtu_pkg::WordW-1]}};
				lower = word;
			end
			default: begin
				upper = word;
				lower = word;
			end
		endcase
	end

	assign pair    = {upper, lower} << count;
	assign shifted = pair[2*bbtu_pkg::WordW-1:bbtu_pkg::WordW];

endmodule

// ===== src/bbtu_core.sv =====
// operation decode, result selection and flag generation for one item
// depends on bbtu_pkg and bbtu_funnel
module bbtu_core (
	input  bbtu_pkg::in_item_t     item,
	input  bbtu_pkg::preset_bank_t presets,
	output bbtu_pkg::out_item_t    res
);

	logic [bbtu_pkg::WordW-1:0] shifted;
	logic [bbtu_pkg::WordW-1:0] bit_sel;
	logic [bbtu_pkg::WordW-1:0] word;

	bbtu_funnel u_funnel (
		.word    (item.data_in),
		.preset  (presets[item.op_select[bbtu_pkg::PresetSelW-1:0]]),
		.shifted (shifted)
	);

	assign bit_sel = {{(bbtu_pkg::WordW-1){1'b0}}, 1'b1} << item.bit_pos;

	always_comb begin
		if (!item.op_select[bbtu_pkg::OpW-1]) begin
			word = shifted;
		end else begin
			case (item.op_select)
				bbtu_pkg::OP_INVERT:   word = ~item.data_in;
				bbtu_pkg::OP_BIT_TEST: word = item.data_in;
				bbtu_pkg::OP_REVERSE:  word = bbtu_pkg::reverse_bits(item.data_in);
				bbtu_pkg::OP_SET:      word = item.data_in | bit_sel;
				bbtu_pkg::OP_CLEAR:    word = item.data_in & ~bit_sel;
				default:               word = item.data_in;
			endcase
		end
	end

	always_comb begin
		res.result         = word;
		res.bit_flag       = word[item.bit_pos];
		res.bit_clear_flag = ~word[item.bit_pos];
		res.masked_zero    = ~|(word & item.test_mask);
		res.masked_nonzero = |(word & item.test_mask);
		res.zero_flag      = ~|word;
		res.nonzero_flag   = |word;
	end

endmodule

// ===== src/barrel_bit_transform_unit.sv =====
// Barrel bit transform unit: 32-bit preset shifts, invert, reverse, bit set/clear
// and result flags for each transfer on the input stream.
//
// Channels:
//   s_axis: one operation per transfer; tuser carries op_select, tdata carries
//           data_in, test_mask and bit_pos.
//   m_axis: one result per input transfer, in order; tdata carries the result
//           word, tuser the six flags.
//   cfg:    writes one of the eight shift presets (index 0..7); writes to other
//           indexes are dropped. cfg_ready is always high. Presets should only
//           change while no transfer is in flight.
// The input register takes the item when the transfer is accepted; the result
// register takes the computed result from it when the result stage advances.
// Throughput is one transfer per cycle while the receiver does not stall; the funnel
// shifter and flag logic sit in one stage between the two registers. When the
// receiver stalls, the result register holds; the input register takes one more
// transfer only if empty, and s_axis_tready stays low while both registers are full.
// Reset clears both stage valid bits and all presets to zero (rotate by 0).
// depends on bbtu_pkg, bbtu_core
module barrel_bit_transform_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// [31:0] data_in, [63:32] test_mask, [68:64] bit_pos, rest zero
	input  logic [bbtu_pkg::InDataW-1:0]     s_axis_tdata,
	// [3:0] op_select, rest zero
	input  logic [bbtu_pkg::InUserW-1:0]     s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [31:0] result
	output logic [bbtu_pkg::OutDataW-1:0]    m_axis_tdata,
	// [0] bit_flag, [1] bit_clear_flag, [2] masked_zero, [3] masked_nonzero,
	// [4] zero_flag, [5] nonzero_flag, rest zero
	output logic [bbtu_pkg::OutUserW-1:0]    m_axis_tuser,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [bbtu_pkg::CfgIdxW-1:0]     cfg_index,
	input  logic [bbtu_pkg::PresetW-1:0]     cfg_data
);

	bbtu_pkg::preset_bank_t presets_q;
	bbtu_pkg::in_item_t     item_s1;
	bbtu_pkg::in_item_t     item_in;
	bbtu_pkg::out_item_t    res_comb;
	bbtu_pkg::out_item_t    res_s2;
	logic                   valid_s1;
	logic                   valid_s2;
	logic                   adv_s1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			presets_q <= '0;
		end else if (cfg_valid && cfg_ready
			&& (cfg_index < bbtu_pkg::CfgIdxW'(bbtu_pkg::NumPresets))) begin
			presets_q[cfg_index[bbtu_pkg::PresetSelW-1:0]] <= cfg_data;
		end
	end

	assign item_in.op_select = s_axis_tuser[bbtu_pkg::OpW-1:0];
	assign item_in.data_in   = s_axis_tdata[bbtu_pkg::WordW-1:0];
	assign item_in.test_mask = s_axis_tdata[2*bbtu_pkg::WordW-1:bbtu_pkg::WordW];
	assign item_in.bit_pos   = s_axis_tdata[bbtu_pkg::InPackW-1:2*bbtu_pkg::WordW];

	// result stage moves when empty or drained this cycle
	assign adv_s1        = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (adv_s1) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1 <= item_in;
		end
		if (adv_s1 && valid_s1) begin
			res_s2 <= res_comb;
		end
	end

	bbtu_core u_core (
		.item    (item_s1),
		.presets (presets_q),
		.res     (res_comb)
	);

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = res_s2.result;
	assign m_axis_tuser  = {{(bbtu_pkg::OutUserW-bbtu_pkg::FlagW){1'b0}},
		res_s2.nonzero_flag, res_s2.zero_flag, res_s2.masked_nonzero,
		res_s2.masked_zero, res_s2.bit_clear_flag, res_s2.bit_flag};

endmodule

// ===== src/bbtu_checker.sv =====
// port-level checks on the barrel bit transform unit's result stream
// depends on bbtu_pkg; bound to barrel_bit_transform_unit
module bbtu_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tready,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [bbtu_pkg::OutDataW-1:0] m_axis_tdata,
	input logic [bbtu_pkg::OutUserW-1:0] m_axis_tuser
);

	// each flag comes with its complement
	a_flag_pairs: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser[0] != m_axis_tuser[1])
			&& (m_axis_tuser[2] != m_axis_tuser[3])
			&& (m_axis_tuser[4] != m_axis_tuser[5]))
		else $error("flag and complement disagree");

	a_zero_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser[4] == (m_axis_tdata == '0)))
		else $error("zero flag does not match result word");

	// a zero word is zero under any mask and has no bit set
	a_zero_implies: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[4]) |-> (m_axis_tuser[2] && !m_axis_tuser[0]))
		else $error("masked or bit flag set on a zero result");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
			(m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
		else $error("result changed while stalled");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input not ready with output empty");

endmodule

bind barrel_bit_transform_unit bbtu_checker u_bbtu_checker (.*);
